// ===== rtl/fsrm_pkg.sv =====
`default_nettype none

package fsrm_pkg;

    // Operation carried by an incoming request. Code 3 has no meaning and is ignored.
    typedef enum logic [1:0] {
        MODE_COMMIT  = 2'd0,
        MODE_RECEIVE = 2'd1,
        MODE_STOP    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        STAT_STORED    = 3'd0,
        STAT_SKIPPED   = 3'd1,
        STAT_DELIVERED = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_END       = 3'd4,
        STAT_IGNORED   = 3'd5,
        STAT_STOPPED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         sender_index;
        logic signed [63:0] frame_time;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [2:0]         slot;
        logic signed [63:0] delivered_time;
        logic               ack_valid;
        logic [7:0]         ack_index;
        logic [31:0]        overruns;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/frame_slot_ring_manager_unit.sv =====
// Frame slot ring manager.
//
// Requests arrive on the item channel (item_valid, item_stall, item) and each one
// produces exactly one result request on the result channel (result_valid,
// result_stall, result). A request moves at a rising edge where valid is high and
// stall is low. A commit stores a frame timestamp in the next ring slot if it is
// free, a receive hands out the oldest stored frame, and a stop ends the stream.
//
// A taken request sits in the input register until the result register is empty or
// emptying; it is then processed and its result is registered in the result register.
// Throughput is one request per cycle while the result side does not stall; every
// update is a few pointer compares and one access to the timestamp memory.
//
// Reset clears every pointer, the queue count, the overrun counter and the stop
// flag, so all slots start free. Timestamp storage is not cleared; it is only read
// for slots that hold a frame. While the result side stalls, the result register
// holds its request, one more request waits in the input register, and item_stall
// rises only once both are occupied.
`default_nettype none

module frame_slot_ring_manager_unit
    import fsrm_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_data_reg, in_data_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    logic    fire, accept;
    result_t step_result;

    // The held request is processed whenever the result register is empty or emptying.
    assign fire       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    fsrm_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data_reg),
        .result (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_data_next  = item;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/fsrm_ram.sv =====
`default_nettype none

module fsrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents before a write to the same address in that cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/fsrm_core.sv =====
`default_nettype none

module fsrm_core
    import fsrm_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOTS);

    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        overruns_reg, overruns_next;
    logic               halted_reg, halted_next;
    logic               consumed_reg, consumed_next;
    logic               byp_reg, byp_next;
    logic [63:0]        byp_data_reg;

    logic [PTR_W-1:0]   wp_inc, rp_inc, rp_prev, rd_addr;
    logic               w_free, store;
    logic [63:0]        rd_data;
    logic signed [63:0] slot_time_cur;

    // The queued slots run from the read pointer up to the write pointer. At most one
    // slot is consumed at a time: the one just before the read pointer, once anything
    // has been delivered. Slot status is therefore implied by the pointers.
    assign wp_inc  = (wp_reg == LAST_SLOT) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc  = (rp_reg == LAST_SLOT) ? '0 : rp_reg + PTR_W'(1);
    assign rp_prev = (rp_reg == '0) ? LAST_SLOT : rp_reg - PTR_W'(1);
    assign w_free  = (count_reg != FULL_COUNT) && !(consumed_reg && (wp_reg == rp_prev));

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        count_next    = count_reg;
        overruns_next = overruns_reg;
        halted_next   = halted_reg;
        consumed_next = consumed_reg;
        store         = 1'b0;
        result        = '0;
        result.status = STAT_IGNORED;
        unique case (mode_t'(item.mode))
            MODE_COMMIT:
            begin
                if (!halted_reg)
                begin
                    if (w_free)
                    begin
                        store         = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        wp_next       = wp_inc;
                        result.status = STAT_STORED;
                        result.slot   = 3'(wp_reg);
                    end
                    else
                    begin
                        if (overruns_reg != '1)
                        begin
                            overruns_next = overruns_reg + 32'd1;
                        end
                        result.status = STAT_SKIPPED;
                    end
                    result.ack_valid = 1'b1;
                    result.ack_index = item.sender_index;
                end
            end
            MODE_RECEIVE:
            begin
                if (count_reg == '0)
                begin
                    result.status = halted_reg ? STAT_END : STAT_EMPTY;
                end
                else
                begin
                    count_next            = count_reg - CNT_W'(1);
                    rp_next               = rp_inc;
                    consumed_next         = 1'b1;
                    result.status         = STAT_DELIVERED;
                    result.slot           = 3'(rp_reg);
                    result.delivered_time = slot_time_cur;
                end
            end
            MODE_STOP:
            begin
                halted_next   = 1'b1;
                result.status = STAT_STOPPED;
            end
            default:
            begin
                result.status = STAT_IGNORED;
            end
        endcase
        result.overruns = overruns_next;
    end

    // The read port always looks at the slot the read pointer will hold next cycle,
    // so the timestamp of the oldest queued slot is ready when a receive arrives.
    assign rd_addr  = fire ? rp_next : rp_reg;
    assign byp_next = fire && store && (wp_reg == rd_addr);
    assign slot_time_cur = byp_reg ? byp_data_reg : rd_data;

    fsrm_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (fire && store),
        .wr_addr (wp_reg),
        .wr_data (item.frame_time),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
            overruns_reg <= '0;
            halted_reg   <= 1'b0;
            consumed_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
            if (fire)
            begin
                wp_reg       <= wp_next;
                rp_reg       <= rp_next;
                count_reg    <= count_next;
                overruns_reg <= overruns_next;
                halted_reg   <= halted_next;
                consumed_reg <= consumed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= item.frame_time;
    end

endmodule

`default_nettype wire

// ===== rtl/fsrm_checker.sv =====
`default_nettype none

module fsrm_checker
    import fsrm_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // A stalled incoming request stays in place unchanged.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("request changed while stalled");

    // A stalled result request stays in place unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // An acknowledge goes with a commit that was stored or skipped, and only then.
    a_ack_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.ack_valid ==
            ((result.status == STAT_STORED) || (result.status == STAT_SKIPPED))))
        else $error("acknowledge does not match status");

    // Only a delivery carries a timestamp.
    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STAT_DELIVERED) |-> (result.delivered_time == '0))
        else $error("timestamp present without delivery");

    // The overrun count never goes down from one result to the next.
    a_overrun_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall) ##1 result_valid |->
            (result.overruns >= $past(result.overruns)))
        else $error("overrun count decreased");

endmodule

bind frame_slot_ring_manager_unit fsrm_checker u_fsrm_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

// Testbench for the frame slot ring manager.
//
// A short scripted run goes first: the empty receive, an unused operation code, the
// extreme timestamps, a full ring that turns a commit into an overrun, and a receive
// that releases the slot consumed before it. The stop flag is sticky and reset
// happens only once, so the rows that stop the stream are held back until after the
// random traffic. The random traffic alternates between commit-heavy, receive-heavy
// and balanced stretches, so the ring keeps filling up, overrunning and draining.
// Every request that is taken is run through a local model of the ring, and each
// result is checked field by field against the oldest outcome still due.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fsrm_pkg::*;

    localparam int SLOTS           = 8;
    localparam int RANDOM_REQUESTS = 925;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;

    // Operation code 3 has no meaning; the block answers it as ignored.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_COMMITTED = 2'd1,
        SLOT_CONSUMED  = 2'd2
    } slot_state_t;

    // One line of the scripted run. Where typed is set, want is the result read off
    // by hand; otherwise the ring model supplies it.
    typedef struct {
        item_t   req;
        int      reps;
        bit      typed;
        result_t want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 18;
    localparam int STOP_ROW    = 12;

    script_row_t script [SCRIPT_ROWS] = '{
        // Receive on an empty ring before any stop: wait.
        '{'{MODE_RECEIVE, 8'h00, 64'sd0}, 1, 1'b1,
          '{STAT_EMPTY, 3'd0, 64'sd0, 1'b0, 8'h00, 32'd0}},
        // The unused operation code, with every other field at its top.
        '{'{MODE_SPARE, 8'hFF, TIME_MAX}, 1, 1'b1,
          '{STAT_IGNORED, 3'd0, 64'sd0, 1'b0, 8'h00, 32'd0}},
        '{'{MODE_COMMIT, 8'h00, TIME_MIN}, 1, 1'b1,
          '{STAT_STORED, 3'd0, 64'sd0, 1'b1, 8'h00, 32'd0}},
        '{'{MODE_COMMIT, 8'hFF, TIME_MAX}, 1, 1'b1,
          '{STAT_STORED, 3'd1, 64'sd0, 1'b1, 8'hFF, 32'd0}},
        '{'{MODE_COMMIT, 8'h5A, 64'shFFFF_FFFF_FFFF_FFFF}, 1, 1'b1,
          '{STAT_STORED, 3'd2, 64'sd0, 1'b1, 8'h5A, 32'd0}},
        // Fill the remaining five slots.
        '{'{MODE_COMMIT, 8'h33, 64'sh0123_4567_89AB_CDEF}, 5, 1'b0, '0},
        // The ring is full, so this commit is skipped but still acknowledged.
        '{'{MODE_COMMIT, 8'hA5, 64'sd0}, 1, 1'b1,
          '{STAT_SKIPPED, 3'd0, 64'sd0, 1'b1, 8'hA5, 32'd1}},
        '{'{MODE_RECEIVE, 8'hFF, TIME_MAX}, 1, 1'b1,
          '{STAT_DELIVERED, 3'd0, TIME_MIN, 1'b0, 8'h00, 32'd1}},
        // Slot 0 is consumed, not free, so this commit overruns too.
        '{'{MODE_COMMIT, 8'hC3, 64'sh5555_5555_5555_5555}, 1, 1'b0, '0},
        // Consuming slot 1 releases slot 0, which the next commit then takes.
        '{'{MODE_RECEIVE, 8'h00, 64'sd0}, 1, 1'b0, '0},
        '{'{MODE_COMMIT, 8'h3C, 64'shAAAA_AAAA_AAAA_AAAA}, 1, 1'b0, '0},
        '{'{MODE_RECEIVE, 8'h00, 64'sd0}, 2, 1'b0, '0},
        // From here on the rows run after the random traffic.
        '{'{MODE_COMMIT, 8'h81, 64'sh0F0F_0F0F_0F0F_0F0F}, 2, 1'b0, '0},
        '{'{MODE_STOP, 8'h00, 64'sd0}, 1, 1'b0, '0},
        // A commit after stop is ignored and not acknowledged.
        '{'{MODE_COMMIT, 8'h7E, 64'sh1234_5678_9ABC_DEF0}, 1, 1'b0, '0},
        // A second stop answers stopped again.
        '{'{MODE_STOP, 8'hFF, TIME_MAX}, 1, 1'b0, '0},
        '{'{MODE_SPARE, 8'h00, 64'sd0}, 1, 1'b0, '0},
        // Frames queued before the stop still come out; then the end of stream.
        '{'{MODE_RECEIVE, 8'h00, 64'sd0}, 9, 1'b0, '0}
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    frame_slot_ring_manager_unit #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Local copy of the ring.
    slot_state_t        ring_state [SLOTS];
    logic signed [63:0] ring_stamp [SLOTS];
    logic [2:0]         commit_ptr;
    logic [2:0]         deliver_ptr;
    int unsigned        waiting_frames;
    logic [31:0]        skip_total;
    logic               halted;

    result_t     pending_outcomes [$];
    int unsigned sent_count     = 0;
    int unsigned got_count      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Works out the result of one request and moves the ring model along.
    function automatic result_t ring_outcome(input item_t req);
        result_t     res;
        int unsigned w;
        int unsigned r;
        int unsigned p;
        res = '0;
        res.status = STAT_IGNORED;
        case (req.mode)
            MODE_COMMIT:
            begin
                if (!halted)
                begin
                    w = 32'(commit_ptr);
                    if (ring_state[w] == SLOT_FREE)
                    begin
                        ring_stamp[w] = req.frame_time;
                        ring_state[w] = SLOT_COMMITTED;
                        if (waiting_frames < SLOTS)
                            waiting_frames++;
                        commit_ptr = 3'((w + 1) % SLOTS);
                        res.status = STAT_STORED;
                        res.slot = 3'(w);
                    end
                    else
                    begin
                        if (skip_total != '1)
                            skip_total++;
                        res.status = STAT_SKIPPED;
                    end
                    res.ack_valid = 1'b1;
                    res.ack_index = req.sender_index;
                end
            end
            MODE_RECEIVE:
            begin
                if (waiting_frames == 0)
                    res.status = halted ? STAT_END : STAT_EMPTY;
                else
                begin
                    r = 32'(deliver_ptr);
                    p = (r + SLOTS - 1) % SLOTS;
                    waiting_frames--;
                    deliver_ptr = 3'((r + 1) % SLOTS);
                    res.delivered_time = ring_stamp[r];
                    ring_state[r] = SLOT_CONSUMED;
                    // The slot consumed just before this one goes back to free.
                    if (ring_state[p] == SLOT_CONSUMED && p != r)
                        ring_state[p] = SLOT_FREE;
                    res.status = STAT_DELIVERED;
                    res.slot = 3'(r);
                end
            end
            MODE_STOP:
            begin
                halted = 1'b1;
                res.status = STAT_STOPPED;
            end
            default:
            begin
            end
        endcase
        res.overruns = skip_total;
        return res;
    endfunction

    // Sender gaps: every fourth stretch of 64 requests goes back to back.
    function automatic int sender_gap();
        if (((sent_count / 64) % 4) == 1)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH #%0d at result %0d: %s got %h want %h",
                 mismatch_count, got_count, what, got, want);
    endtask

    // Offers one request, holds it until it is taken, and records what it must give.
    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic offer(input item_t req, input bit typed, input result_t want);
        int      gap;
        result_t guess;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (item_stall);
        guess = ring_outcome(req);
        pending_outcomes.push_back(typed ? want : guess);
        sent_count++;
    endtask

    // Request stream: scripted rows up to the stop, random traffic, then the rows
    // that stop the stream. Ends the run once every outcome has been seen.
    initial
    begin : request_stream
        item_t req;
        int    n;
        int    k;
        int    lean;
        int    pick;
        for (k = 0; k < SLOTS; k++)
        begin
            ring_state[k] = SLOT_FREE;
            ring_stamp[k] = '0;
        end
        commit_ptr = '0;
        deliver_ptr = '0;
        waiting_frames = 0;
        skip_total = '0;
        halted = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < STOP_ROW; n++)
            repeat (script[n].reps) offer(script[n].req, script[n].typed, script[n].want);

        // Random traffic with no stop in it. The mix of commits and receives
        // changes every 40 requests so that the ring both overruns and runs dry.
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            lean = (n / 40) % 3;
            pick = $urandom_range(0, 99);
            req.sender_index = 8'($urandom_range(0, 255));
            req.frame_time = {$urandom, $urandom};
            if ($urandom_range(0, 15) == 0)
                req.frame_time = $urandom_range(0, 1) ? TIME_MIN : TIME_MAX;
            if (pick < 3)
                req.mode = MODE_SPARE;
            else if (lean == 0)
                req.mode = (pick < 75) ? MODE_COMMIT : MODE_RECEIVE;
            else if (lean == 1)
                req.mode = (pick < 28) ? MODE_COMMIT : MODE_RECEIVE;
            else
                req.mode = (pick < 52) ? MODE_COMMIT : MODE_RECEIVE;
            offer(req, 1'b0, '0);
        end

        for (n = STOP_ROW; n < SCRIPT_ROWS; n++)
            repeat (script[n].reps) offer(script[n].req, script[n].typed, script[n].want);
        item_valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // Let the clock run on so that any stray result still shows up.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side. Each result waits behind a random stall, except in every fourth stretch
    // of 64 results; one long hold-off lets the block fill up and push back on the request side.
    initial
    begin : result_sink
        int      hold;
        bit      held_off;
        result_t want;
        held_off = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held_off && got_count >= 200)
            begin
                held_off = 1'b1;
                hold = HOLD_OFF_CYCLES;
            end
            else if (((got_count / 64) % 4) == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 8);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);

            if (pending_outcomes.size() == 0)
                report("result with nothing due, status", 64'(result.status), '0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.status !== want.status)
                    report("status", 64'(result.status), 64'(want.status));
                if (result.slot !== want.slot)
                    report("slot", 64'(result.slot), 64'(want.slot));
                if (result.delivered_time !== want.delivered_time)
                    report("delivered_time", result.delivered_time, want.delivered_time);
                if (result.ack_valid !== want.ack_valid)
                    report("ack_valid", 64'(result.ack_valid), 64'(want.ack_valid));
                if (result.ack_index !== want.ack_index)
                    report("ack_index", 64'(result.ack_index), 64'(want.ack_index));
                if (result.overruns !== want.overruns)
                    report("overruns", 64'(result.overruns), 64'(want.overruns));
            end
            got_count++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fsrm_pkg.sv
rtl/fsrm_ram.sv
rtl/fsrm_core.sv
rtl/frame_slot_ring_manager_unit.sv
rtl/fsrm_checker.sv
tb/tb_top.sv
